FILE: rtl/efp_pkg.sv
package efp_pkg;

    // coordinate and count widths
    localparam int COORD_BITS   = 32;
    localparam int FRAC_BITS    = 28;
    localparam int ITER_BITS    = 16;
    localparam int COLOR_BITS   = 8;

    // derived widths
    localparam int PROD_BITS    = 2 * COORD_BITS;
    localparam int RAD_BITS     = COORD_BITS - 1;
    localparam int RAD_SQ_BITS  = 2 * RAD_BITS;
    localparam int SUM_BITS     = PROD_BITS - FRAC_BITS + 2;
    localparam int NUM_BITS     = ITER_BITS + COLOR_BITS + 1;
    localparam int DIV_CNT_BITS = $clog2(COLOR_BITS);

    // configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE          = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CONST_RE      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CONST_IM      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ITERS     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ESCAPE_RADIUS = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_COLORS    = 3'd5;

    // fractal modes
    localparam logic MODE_MANDELBROT = 1'b0;
    localparam logic MODE_JULIA      = 1'b1;

    // configuration reset values
    localparam logic [ITER_BITS-1:0]  MAX_ITERS_RST     = 16'd256;
    localparam logic [RAD_BITS-1:0]   ESCAPE_RADIUS_RST = 31'h2000_0000;
    localparam logic [COLOR_BITS-1:0] NUM_COLORS_RST    = 8'd16;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_re;
        logic signed [COORD_BITS-1:0] point_im;
    } in_item_t;

    typedef struct packed {
        logic [ITER_BITS-1:0]  iter_count;
        logic [COLOR_BITS-1:0] color_index;
    } out_item_t;

    typedef struct packed {
        logic                         mode;
        logic signed [COORD_BITS-1:0] const_re;
        logic signed [COORD_BITS-1:0] const_im;
        logic [ITER_BITS-1:0]         max_iters;
        logic [RAD_BITS-1:0]          escape_radius;
        logic [COLOR_BITS-1:0]        num_colors;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic update;
        logic color_mul;
        logic div_step;
        logic emit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic done;
    } dp_status_t;

endpackage

FILE: rtl/efp_datapath.sv
module efp_datapath (
    input  logic                aclk,
    input  efp_pkg::dp_cmd_t    cmd,
    input  efp_pkg::cfg_t       cfg,
    input  efp_pkg::in_item_t   point,
    output efp_pkg::dp_status_t status,
    output efp_pkg::out_item_t  result
);
    import efp_pkg::*;

    logic signed [COORD_BITS-1:0] zr_reg, zi_reg, cr_reg, ci_reg;
    logic signed [PROD_BITS-1:0]  xx_reg, yy_reg, xy_reg;
    logic signed [PROD_BITS-1:0]  xx_next, yy_next, xy_next;
    logic [RAD_SQ_BITS-1:0]       r2_reg;
    logic [ITER_BITS-1:0]         iter_reg;
    logic [ITER_BITS-1:0]         res_iter_reg, res_iter_next;
    logic                         tested_reg;

    logic signed [PROD_BITS-1:0]  diff;
    logic signed [PROD_BITS-1:0]  sh_re, sh_im;
    logic signed [SUM_BITS-1:0]   nr, ni;
    logic [PROD_BITS-1:0]         mag_sq;
    logic                         sq_esc, run, fit_re, fit_im, done;

    logic [NUM_BITS-1:0]          rem_reg, dvs_reg;
    logic [COLOR_BITS-1:0]        quo_reg;
    logic                         q_bit;

    // squares and cross product of the current z
    assign xx_next = zr_reg * zr_reg;
    assign yy_next = zi_reg * zi_reg;
    assign xy_next = zr_reg * zi_reg;

    // next z, floored fixed point
    assign diff  = xx_reg - yy_reg;
    assign sh_re = diff >>> FRAC_BITS;
    assign sh_im = xy_reg >>> (FRAC_BITS - 1);
    assign nr    = $signed(SUM_BITS'(sh_re)) + $signed(SUM_BITS'(cr_reg));
    assign ni    = $signed(SUM_BITS'(sh_im)) + $signed(SUM_BITS'(ci_reg));

    // component overflow: upper bits not a sign extension
    assign fit_re = (nr[SUM_BITS-1:COORD_BITS-1] == '0) || (nr[SUM_BITS-1:COORD_BITS-1] == '1);
    assign fit_im = (ni[SUM_BITS-1:COORD_BITS-1] == '0) || (ni[SUM_BITS-1:COORD_BITS-1] == '1);

    // escape test of the current z uses the squares just formed
    assign mag_sq = PROD_BITS'($unsigned(xx_reg)) + PROD_BITS'($unsigned(yy_reg));
    assign sq_esc = tested_reg && (mag_sq > PROD_BITS'(r2_reg));
    assign run    = iter_reg < cfg.max_iters;
    assign done   = sq_esc || !run || !(fit_re && fit_im);

    always_comb begin
        if (sq_esc) begin
            res_iter_next = iter_reg - 1'b1;
        end else if (!run) begin
            res_iter_next = '0;
        end else begin
            res_iter_next = iter_reg;
        end
    end

    assign status.done = done;

    // iteration registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            if (cfg.mode == MODE_JULIA) begin
                zr_reg <= point.point_re;
                zi_reg <= point.point_im;
                cr_reg <= cfg.const_re;
                ci_reg <= cfg.const_im;
            end else begin
                zr_reg <= '0;
                zi_reg <= '0;
                cr_reg <= point.point_re;
                ci_reg <= point.point_im;
            end
            r2_reg     <= RAD_SQ_BITS'(cfg.escape_radius) * RAD_SQ_BITS'(cfg.escape_radius);
            iter_reg   <= ITER_BITS'(1);
            tested_reg <= 1'b0;
        end
        if (cmd.mul) begin
            xx_reg <= xx_next;
            yy_reg <= yy_next;
            xy_reg <= xy_next;
        end
        if (cmd.update) begin
            res_iter_reg <= res_iter_next;
            if (!done) begin
                zr_reg     <= nr[COORD_BITS-1:0];
                zi_reg     <= ni[COORD_BITS-1:0];
                iter_reg   <= iter_reg + 1'b1;
                tested_reg <= 1'b1;
            end
        end
    end

    // restoring divider for the palette index, one quotient bit per step
    assign q_bit = rem_reg >= dvs_reg;

    always_ff @(posedge aclk) begin
        if (cmd.color_mul) begin
            rem_reg <= NUM_BITS'(res_iter_reg) * NUM_BITS'(cfg.num_colors)
                       + NUM_BITS'(cfg.max_iters) - NUM_BITS'(1);
            dvs_reg <= NUM_BITS'(cfg.max_iters) << (COLOR_BITS - 1);
        end
        if (cmd.div_step) begin
            if (q_bit) begin
                rem_reg <= rem_reg - dvs_reg;
            end
            dvs_reg <= dvs_reg >> 1;
            quo_reg <= {quo_reg[COLOR_BITS-2:0], q_bit};
        end
    end

    assign result.iter_count  = res_iter_reg;
    assign result.color_index = (cfg.max_iters == '0) ? '0 : quo_reg;

endmodule

FILE: rtl/efp_ctrl.sv
module efp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                out_free,
    input  efp_pkg::dp_status_t status,
    output efp_pkg::dp_cmd_t    cmd
);
    import efp_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_UPD  = 3'd2;
    localparam logic [2:0] ST_CMUL = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(COLOR_BITS - 1);

    logic [2:0]              state_reg, state_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                cmd.update = 1'b1;
                state_next = status.done ? ST_CMUL : ST_MUL;
            end
            ST_CMUL: begin
                cmd.color_mul = 1'b1;
                cnt_next      = '0;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // an accepted transaction starts the iteration loop
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_MUL))
        else $error("accepted transaction did not start iteration");

    // a result is only handed over when the output stage can take it
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> out_free)
        else $error("result emitted into a full output stage");

    // step counter idles at zero outside the divider
    a_cnt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_DIV) |-> (cnt_reg == '0))
        else $error("divider step count left nonzero");

    // at most one datapath command per cycle
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.mul, cmd.update, cmd.color_mul, cmd.div_step, cmd.emit}))
        else $error("overlapping datapath commands");

endmodule

FILE: rtl/escape_time_fractal_pixel_top.sv
// Escape-time pixel engine for Mandelbrot and Julia sets in signed Q4.28. Each
// transaction carries one complex point; one result transaction follows with the
// first escaping iteration (0 if none below max_iters) and the palette index
// ceil(iter_count*num_colors/max_iters). One point is worked at a time on three
// 32x32 multipliers; each pass squares, then adds and runs the escape test.
// The passes run are the escape iteration when a component overflows, one more
// when the radius test trips, and max_iters (at least one) when z stays bounded;
// max_iters resets to 256. The palette index comes from an 8-step restoring
// divider. The next point is taken while a finished result still waits in the
// output register. Registers must be written by the user only while idle,
// through cfg_wr_en/cfg_index/cfg_wr_data; the block does not enforce this.
module escape_time_fractal_pixel_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  efp_pkg::in_item_t                    s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output efp_pkg::out_item_t                   m_data,
    input  logic                                 cfg_wr_en,
    input  logic [efp_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [efp_pkg::COORD_BITS-1:0]       cfg_wr_data
);
    import efp_pkg::*;

    cfg_t       cfg_reg;
    dp_cmd_t    cmd;
    dp_status_t status;
    out_item_t  result;
    out_item_t  m_data_reg;
    logic       m_valid_reg;
    logic       out_free;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode          <= MODE_MANDELBROT;
            cfg_reg.const_re      <= '0;
            cfg_reg.const_im      <= '0;
            cfg_reg.max_iters     <= MAX_ITERS_RST;
            cfg_reg.escape_radius <= ESCAPE_RADIUS_RST;
            cfg_reg.num_colors    <= NUM_COLORS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MODE:          cfg_reg.mode          <= cfg_wr_data[0];
                CFG_CONST_RE:      cfg_reg.const_re      <= $signed(cfg_wr_data);
                CFG_CONST_IM:      cfg_reg.const_im      <= $signed(cfg_wr_data);
                CFG_MAX_ITERS:     cfg_reg.max_iters     <= cfg_wr_data[ITER_BITS-1:0];
                CFG_ESCAPE_RADIUS: cfg_reg.escape_radius <= cfg_wr_data[RAD_BITS-1:0];
                CFG_NUM_COLORS:    cfg_reg.num_colors    <= cfg_wr_data[COLOR_BITS-1:0];
                default: ;
            endcase
        end
    end

    efp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd)
    );

    efp_datapath u_datapath (
        .aclk   (aclk),
        .cmd    (cmd),
        .cfg    (cfg_reg),
        .point  (s_data),
        .status (status),
        .result (result)
    );

    // output register
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: verif/fractal_pixel_checker.sv
module fractal_pixel_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  efp_pkg::in_item_t                s_data,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  efp_pkg::out_item_t               m_data,
    input  logic                             cfg_wr_en,
    input  logic [efp_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [efp_pkg::COORD_BITS-1:0]   cfg_wr_data,
    output int                               pending,
    output int                               fail_count
);
    import efp_pkg::*;

    // shadow of the register file, follows every write seen on the config port
    cfg_t      cur_cfg;
    out_item_t expected_pixels[$];

    // true when v is representable as a signed coordinate
    function automatic bit fits_coord(input logic signed [63:0] v);
        logic signed [63:0] hi;
        hi = v >>> (COORD_BITS - 1);
        return (hi == 64'sd0) || (hi == -64'sd1);
    endfunction

    // first iterate of z = z*z + c that leaves the radius or the coordinate range
    function automatic logic [ITER_BITS-1:0] escape_iteration(
        input logic signed [63:0]  zr_start,
        input logic signed [63:0]  zi_start,
        input logic signed [63:0]  c_re,
        input logic signed [63:0]  c_im,
        input logic [ITER_BITS-1:0] limit,
        input logic [RAD_BITS-1:0]  radius
    );
        logic signed [63:0] zr;
        logic signed [63:0] zi;
        logic signed [63:0] diff;
        logic signed [63:0] prod_xy;
        logic signed [63:0] nr;
        logic signed [63:0] ni;
        logic [63:0]        mag_sq;
        logic [63:0]        rad_sq;
        rad_sq = 64'(radius) * 64'(radius);
        zr = zr_start;
        zi = zi_start;
        for (int unsigned i = 1; i < limit; i++) begin
            diff    = zr * zr - zi * zi;
            prod_xy = zr * zi;
            nr = (diff >>> FRAC_BITS) + c_re;
            ni = (prod_xy >>> (FRAC_BITS - 1)) + c_im;
            // a component outside the coordinate range counts as escaped
            if (!fits_coord(nr) || !fits_coord(ni))
                return ITER_BITS'(i);
            // magnitude compared as unsigned squares, wraps like the hardware sum
            mag_sq = nr * nr + ni * ni;
            if (mag_sq > rad_sq)
                return ITER_BITS'(i);
            zr = nr;
            zi = ni;
        end
        return '0;
    endfunction

    // ceil(iter * colors / limit), zero when the limit is zero
    function automatic logic [COLOR_BITS-1:0] palette_index(
        input logic [ITER_BITS-1:0]  iter,
        input logic [COLOR_BITS-1:0] colors,
        input logic [ITER_BITS-1:0]  limit
    );
        logic [63:0] num;
        if (limit == '0)
            return '0;
        num = 64'(iter) * 64'(colors) + 64'(limit) - 64'd1;
        return COLOR_BITS'(num / 64'(limit));
    endfunction

    function automatic out_item_t predict_pixel(input in_item_t p);
        out_item_t res;
        if (cur_cfg.mode == MODE_JULIA)
            res.iter_count = escape_iteration($signed(p.point_re), $signed(p.point_im),
                                              $signed(cur_cfg.const_re),
                                              $signed(cur_cfg.const_im),
                                              cur_cfg.max_iters, cur_cfg.escape_radius);
        else
            res.iter_count = escape_iteration(64'sd0, 64'sd0,
                                              $signed(p.point_re), $signed(p.point_im),
                                              cur_cfg.max_iters, cur_cfg.escape_radius);
        res.color_index = palette_index(res.iter_count, cur_cfg.num_colors,
                                        cur_cfg.max_iters);
        return res;
    endfunction

    // scoreboard: compare results, queue predictions, track register writes
    always @(posedge aclk) begin
        out_item_t want;
        int        errs;
        errs = 0;
        if (!aresetn) begin
            cur_cfg.mode          = MODE_MANDELBROT;
            cur_cfg.const_re      = '0;
            cur_cfg.const_im      = '0;
            cur_cfg.max_iters     = MAX_ITERS_RST;
            cur_cfg.escape_radius = ESCAPE_RADIUS_RST;
            cur_cfg.num_colors    = NUM_COLORS_RST;
            expected_pixels.delete();
            pending    <= 0;
            fail_count <= 0;
        end else begin
            // result transaction against the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected result: iter_count %0d color_index %0d",
                           m_data.iter_count, m_data.color_index);
                    errs++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_data.iter_count !== want.iter_count) begin
                        $error("iter_count mismatch: expected %0d, actual %0d",
                               want.iter_count, m_data.iter_count);
                        errs++;
                    end
                    if (m_data.color_index !== want.color_index) begin
                        $error("color_index mismatch: expected %0d, actual %0d",
                               want.color_index, m_data.color_index);
                        errs++;
                    end
                end
            end
            // point transaction
            if (s_valid && s_ready)
                expected_pixels.push_back(predict_pixel(s_data));
            // register write, bits above each register's width dropped
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MODE:          cur_cfg.mode          = cfg_wr_data[0];
                    CFG_CONST_RE:      cur_cfg.const_re      = cfg_wr_data;
                    CFG_CONST_IM:      cur_cfg.const_im      = cfg_wr_data;
                    CFG_MAX_ITERS:     cur_cfg.max_iters     = cfg_wr_data[ITER_BITS-1:0];
                    CFG_ESCAPE_RADIUS: cur_cfg.escape_radius = cfg_wr_data[RAD_BITS-1:0];
                    CFG_NUM_COLORS:    cur_cfg.num_colors    = cfg_wr_data[COLOR_BITS-1:0];
                    default: ;
                endcase
            end
            pending    <= expected_pixels.size();
            fail_count <= fail_count + errs;
        end
    end

endmodule

FILE: verif/escape_time_fractal_pixel_top_tb.sv
module escape_time_fractal_pixel_top_tb;
    import efp_pkg::*;

    localparam int WATCHDOG_LIMIT = 600_000;

    // indexes past the end of the register list, writes there must do nothing
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;

    // Q4.28 values
    localparam logic [COORD_BITS-1:0] Q_ZERO    = 32'h0000_0000;
    localparam logic [COORD_BITS-1:0] Q_LSB     = 32'h0000_0001;
    localparam logic [COORD_BITS-1:0] Q_NEG_LSB = 32'hFFFF_FFFF;
    localparam logic [COORD_BITS-1:0] Q_ONE     = 32'h1000_0000;
    localparam logic [COORD_BITS-1:0] Q_TWO     = 32'h2000_0000;
    localparam logic [COORD_BITS-1:0] Q_THREE   = 32'h3000_0000;
    localparam logic [COORD_BITS-1:0] Q_NEG_TWO = 32'hE000_0000;
    localparam logic [COORD_BITS-1:0] Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [COORD_BITS-1:0] Q_MIN     = 32'h8000_0000;
    localparam logic [RAD_BITS-1:0]   RAD_MAX   = 31'h7FFF_FFFF;
    localparam logic [RAD_BITS-1:0]   RAD_TWO   = 31'h2000_0000;

    typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_HELD} rdy_mode_t;

    logic                    aclk;
    logic                    aresetn     = 1'b0;
    logic                    s_valid     = 1'b0;
    logic                    s_ready;
    in_item_t                s_data      = '0;
    logic                    m_valid;
    logic                    m_ready     = 1'b0;
    out_item_t               m_data;
    logic                    cfg_wr_en   = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index   = CFG_MODE;
    logic [COORD_BITS-1:0]   cfg_wr_data = '0;

    int        pending;
    int        fail_count;
    int        idle_cycles = 0;
    int        burst_left  = 0;
    bit        gaps_on     = 1'b1;
    rdy_mode_t rdy_mode    = RDY_ALWAYS;
    int        rdy_left    = 0;

    escape_time_fractal_pixel_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    fractal_pixel_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .pending     (pending),
        .fail_count  (fail_count)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // result backpressure, random pattern switched when its hold count runs out
    always @(posedge aclk) begin
        if (rdy_left == 0) begin
            rdy_mode <= rdy_mode_t'($urandom_range(0, 3));
            rdy_left <= $urandom_range(20, 300);
        end else begin
            rdy_left <= rdy_left - 1;
        end
        case (rdy_mode)
            RDY_ALWAYS: m_ready <= 1'b1;
            RDY_COIN:   m_ready <= ($urandom_range(0, 1) != 0);
            RDY_SPARSE: m_ready <= ($urandom_range(0, 7) == 0);
            default:    m_ready <= (rdy_left < 4);
        endcase
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // point generator, mostly near the interesting region
    function automatic logic [COORD_BITS-1:0] rand_coord();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
        else if (sel < 75)
            return $urandom();
        else if (sel < 88)
            return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
        case ($urandom_range(0, 6))
            0:       return Q_ZERO;
            1:       return Q_MAX;
            2:       return Q_MIN;
            3:       return Q_TWO;
            4:       return Q_NEG_TWO;
            5:       return Q_ONE;
            default: return Q_NEG_LSB;
        endcase
    endfunction

    function automatic logic [COORD_BITS-1:0] rand_julia_const();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
        else if (sel < 9)
            return $urandom();
        return ($urandom_range(0, 1) != 0) ? Q_MAX : Q_MIN;
    endfunction

    // one point transaction, with sender gaps between bursts
    task automatic send_point(input logic [COORD_BITS-1:0] re,
                              input logic [COORD_BITS-1:0] im);
        int gap;
        if (gaps_on) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 5);
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        s_valid         <= 1'b1;
        s_data.point_re <= re;
        s_data.point_im <= im;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // stop sending and wait until every result is back
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [COORD_BITS-1:0]   data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
    endtask

    // write the whole register file, unused upper bits filled with noise
    task automatic reconfigure(input logic                  mode,
                               input logic [COORD_BITS-1:0] c_re,
                               input logic [COORD_BITS-1:0] c_im,
                               input logic [ITER_BITS-1:0]  limit,
                               input logic [RAD_BITS-1:0]   radius,
                               input logic [COLOR_BITS-1:0] colors);
        logic [COORD_BITS-1:0] raw;
        settle();
        raw = $urandom();
        raw[0] = mode;
        write_reg(CFG_MODE, raw);
        write_reg(CFG_CONST_RE, c_re);
        write_reg(CFG_CONST_IM, c_im);
        raw = $urandom();
        raw[ITER_BITS-1:0] = limit;
        write_reg(CFG_MAX_ITERS, raw);
        raw = $urandom();
        raw[RAD_BITS-1:0] = radius;
        write_reg(CFG_ESCAPE_RADIUS, raw);
        raw = $urandom();
        raw[COLOR_BITS-1:0] = colors;
        write_reg(CFG_NUM_COLORS, raw);
        write_reg(CFG_SPARE_LO, $urandom());
        write_reg(CFG_SPARE_HI, $urandom());
        cfg_wr_en <= 1'b0;
    endtask

    // random settings, small iteration limits for most phases
    task automatic random_phase(input int n_items);
        logic                  mode;
        logic [ITER_BITS-1:0]  limit;
        logic [RAD_BITS-1:0]   radius;
        logic [COLOR_BITS-1:0] colors;
        int                    sel;
        mode = ($urandom_range(0, 1) != 0) ? MODE_JULIA : MODE_MANDELBROT;
        sel = $urandom_range(0, 99);
        if (sel < 70)      limit = ITER_BITS'($urandom_range(2, 48));
        else if (sel < 85) limit = ITER_BITS'($urandom_range(49, 300));
        else if (sel < 95) limit = MAX_ITERS_RST;
        else               limit = ITER_BITS'($urandom_range(0, 1));
        sel = $urandom_range(0, 99);
        if (sel < 60)      radius = RAD_BITS'($urandom_range(32'h1800_0000, 32'h2800_0000));
        else if (sel < 80) radius = RAD_TWO;
        else if (sel < 90) radius = RAD_BITS'($urandom());
        else if (sel < 95) radius = RAD_MAX;
        else               radius = '0;
        sel = $urandom_range(0, 99);
        if (sel < 80)      colors = COLOR_BITS'($urandom_range(1, 255));
        else if (sel < 90) colors = 8'd255;
        else if (sel < 95) colors = 8'd1;
        else               colors = 8'd0;
        reconfigure(mode, rand_julia_const(), rand_julia_const(), limit, radius, colors);
        gaps_on = ($urandom_range(0, 3) != 0);
        repeat (n_items) send_point(rand_coord(), rand_coord());
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: Mandelbrot, 256 iterations, radius 2
        send_point(Q_ZERO, Q_ZERO);
        send_point(Q_TWO, Q_ZERO);
        send_point(Q_NEG_TWO, Q_ZERO);
        send_point(Q_MIN, Q_MIN);
        send_point(Q_MAX, Q_MAX);
        send_point(Q_MAX, Q_MIN);
        send_point(Q_ZERO, Q_ONE);
        send_point(32'hF400_0000, 32'h0199_999A);

        // Julia at the origin, widest radius so only overflow can escape
        reconfigure(MODE_JULIA, Q_ZERO, Q_ZERO, 16'd64, RAD_MAX, 8'd255);
        send_point(Q_THREE, Q_ZERO);
        send_point(Q_MIN, Q_ZERO);
        send_point(Q_ONE, Q_ZERO);
        send_point(Q_ZERO, Q_ONE);
        send_point(Q_MAX, Q_MAX);

        // extreme Julia constants
        reconfigure(MODE_JULIA, Q_MAX, Q_MIN, 16'd2, RAD_TWO, 8'd1);
        send_point(Q_ZERO, Q_ZERO);
        send_point(Q_MIN, Q_MIN);

        // zero limit, zero radius, zero palette
        reconfigure(MODE_MANDELBROT, Q_ZERO, Q_ZERO, 16'd0, '0, 8'd0);
        send_point(Q_MAX, Q_MAX);
        send_point(Q_ZERO, Q_ZERO);

        // a limit of one never iterates
        reconfigure(MODE_MANDELBROT, Q_ZERO, Q_ZERO, 16'd1, '0, 8'd255);
        send_point(Q_ONE, Q_ZERO);

        // zero radius: only an exact zero iterate stays in
        reconfigure(MODE_MANDELBROT, Q_ZERO, Q_ZERO, 16'd2, '0, 8'd255);
        send_point(Q_ZERO, Q_ZERO);
        send_point(Q_LSB, Q_ZERO);
        send_point(Q_ZERO, Q_NEG_LSB);

        // largest iteration limit, one full-length run
        reconfigure(MODE_MANDELBROT, Q_ZERO, Q_ZERO, 16'hFFFF, RAD_TWO, 8'd255);
        send_point(Q_ZERO, Q_ZERO);
        send_point(Q_ONE, Q_ONE);

        repeat (12) random_phase(84);

        settle();
        repeat (40) @(posedge aclk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
